### design/fmdd_pkg.sv
// ----------------------------------------------------------------------------
// fmdd_pkg
// Shared types and constants for the framed motor direction decoder.
// ----------------------------------------------------------------------------
package fmdd_pkg;

  localparam int NUM_MOTORS = 8;
  // Only the first eight motors have pins on the 16-bit drive word
  localparam int PIN_MOTORS = (NUM_MOTORS < 8) ? NUM_MOTORS : 8;

  localparam int BYTE_W  = 8;
  localparam int DRIVE_W = 16;
  localparam int ID_W    = 5;
  localparam int MIDX_W  = 3;

  localparam logic [BYTE_W-1:0] START_BYTE  = 8'h40;
  localparam logic [BYTE_W-1:0] STOP_BYTE   = 8'h2A;
  localparam logic [BYTE_W-1:0] NACK_BYTE   = 8'h4E;
  localparam logic [BYTE_W-1:0] ID_MASK     = 8'hF8;
  localparam logic [BYTE_W-1:0] SIGN_MASK   = 8'h04;
  localparam logic [BYTE_W-1:0] MAG_HI_MASK = 8'h03;

  localparam logic [1:0] PAIR_OFF = 2'b00;
  localparam logic [1:0] PAIR_R   = 2'b01;
  localparam logic [1:0] PAIR_L   = 2'b10;

  typedef enum logic [2:0] {
    PH_WAIT  = 3'd0,
    PH_COUNT = 3'd1,
    PH_HIGH  = 3'd2,
    PH_LOW   = 3'd3,
    PH_STOP  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    OP_NOP    = 3'd0,
    OP_RELOAD = 3'd1,
    OP_ENTRY  = 3'd2,
    OP_COMMIT = 3'd3,
    OP_NACK   = 3'd4
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [MIDX_W-1:0] motor_idx;
    logic [1:0]        pair;
  } cmd_t;

endpackage

### design/fmdd_in_if.sv
// ----------------------------------------------------------------------------
// fmdd_in_if
// Byte request channel: valid/ready with one received serial byte.
// ----------------------------------------------------------------------------
interface fmdd_in_if
  import fmdd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### design/fmdd_out_if.sv
// ----------------------------------------------------------------------------
// fmdd_out_if
// Result request channel: committed drive pins and reply flags.
// ----------------------------------------------------------------------------
interface fmdd_out_if
  import fmdd_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [DRIVE_W-1:0] drive_pins;
  logic               nack;
  logic               frame_applied;

  modport source (output valid, output drive_pins, output nack, output frame_applied,
                  input ready);
  modport sink   (input valid, input drive_pins, input nack, input frame_applied,
                  output ready);
endinterface

### design/fmdd_front.sv
// ----------------------------------------------------------------------------
// fmdd_front
// Frame parser: tracks the frame phase and turns each byte into a command.
// ----------------------------------------------------------------------------
module fmdd_front
  import fmdd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [BYTE_W-1:0] rx_byte,
  output cmd_t              cmd
);

  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] entries_left_r, entries_left_nxt;
  logic [BYTE_W-1:0] hi_hold_r, hi_hold_nxt;
  logic [BYTE_W-1:0] entries_dec;

  logic [ID_W-1:0]   ent_id;
  logic              ent_sign;
  logic              ent_mag_nz;

  assign entries_dec = entries_left_r - 8'd1;

  always_comb begin
    phase_nxt        = phase_r;
    entries_left_nxt = entries_left_r;
    hi_hold_nxt      = hi_hold_r;
    case (phase_r)
      PH_COUNT: begin
        entries_left_nxt = rx_byte;
        phase_nxt        = (rx_byte == '0) ? PH_STOP : PH_HIGH;
      end
      PH_HIGH: begin
        hi_hold_nxt = rx_byte;
        phase_nxt   = PH_LOW;
      end
      PH_LOW: begin
        entries_left_nxt = entries_dec;
        phase_nxt        = (entries_dec == '0) ? PH_STOP : PH_HIGH;
      end
      PH_STOP: begin
        if (rx_byte == STOP_BYTE) begin
          phase_nxt = PH_WAIT;
        end else if (rx_byte == START_BYTE) begin
          phase_nxt = PH_COUNT;
        end else begin
          phase_nxt = PH_WAIT;
        end
      end
      default: begin
        phase_nxt = (rx_byte == START_BYTE) ? PH_COUNT : PH_WAIT;
      end
    endcase
  end

  assign ent_id     = ID_W'((hi_hold_r & ID_MASK) >> 3);
  assign ent_sign   = |(hi_hold_r & SIGN_MASK);
  assign ent_mag_nz = (|(hi_hold_r & MAG_HI_MASK)) | (|rx_byte);

  always_comb begin
    cmd.op        = OP_NOP;
    cmd.motor_idx = MIDX_W'(ent_id - 5'd1);
    cmd.pair      = !ent_mag_nz ? PAIR_OFF : (ent_sign ? PAIR_R : PAIR_L);
    case (phase_r)
      PH_COUNT, PH_HIGH: begin
        cmd.op = OP_NOP;
      end
      PH_LOW: begin
        // drop ids with no pins
        if (ent_id != '0 && ent_id <= ID_W'(PIN_MOTORS)) begin
          cmd.op = OP_ENTRY;
        end
      end
      PH_STOP: begin
        cmd.op = (rx_byte == STOP_BYTE) ? OP_COMMIT : OP_NACK;
      end
      default: begin
        if (rx_byte == START_BYTE) begin
          cmd.op = OP_RELOAD;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_WAIT;
      entries_left_r <= '0;
      hi_hold_r      <= '0;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      entries_left_r <= entries_left_nxt;
      hi_hold_r      <= hi_hold_nxt;
    end
  end

endmodule

### design/fmdd_cmd_queue.sv
// ----------------------------------------------------------------------------
// fmdd_cmd_queue
// Two-entry command queue between the parser and the drive back end.
// ----------------------------------------------------------------------------
module fmdd_cmd_queue
  import fmdd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t pop_cmd
);

  cmd_t       mem [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign pop_cmd = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule

### design/fmdd_back.sv
// ----------------------------------------------------------------------------
// fmdd_back
// Drive back end: applies commands to the pending shadow and committed pins
// and holds one result in an output register.
// ----------------------------------------------------------------------------
module fmdd_back
  import fmdd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  cmd_t               cmd,
  output logic               cmd_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DRIVE_W-1:0] out_drive,
  output logic               out_nack,
  output logic               out_applied
);

  logic [DRIVE_W-1:0] pending_r, pending_nxt;
  logic [DRIVE_W-1:0] committed_r, committed_nxt;
  logic               valid_r;
  logic [DRIVE_W-1:0] drive_r;
  logic               nack_r, nack_nxt;
  logic               applied_r, applied_nxt;

  // advance when the output register is empty or being taken
  assign cmd_pop = cmd_valid && (!valid_r || out_ready);

  always_comb begin
    pending_nxt   = pending_r;
    committed_nxt = committed_r;
    nack_nxt      = 1'b0;
    applied_nxt   = 1'b0;
    case (cmd.op)
      OP_RELOAD: begin
        pending_nxt = committed_r;
      end
      OP_ENTRY: begin
        pending_nxt[{cmd.motor_idx, 1'b0} +: 2] = cmd.pair;
      end
      OP_COMMIT: begin
        committed_nxt = pending_r;
        applied_nxt   = 1'b1;
      end
      OP_NACK: begin
        pending_nxt = committed_r;
        nack_nxt    = 1'b1;
      end
      default: begin
        pending_nxt = pending_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= '0;
      committed_r <= '0;
      valid_r     <= 1'b0;
    end else begin
      if (cmd_pop) begin
        pending_r   <= pending_nxt;
        committed_r <= committed_nxt;
        valid_r     <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      drive_r   <= committed_nxt;
      nack_r    <= nack_nxt;
      applied_r <= applied_nxt;
    end
  end

  assign out_valid   = valid_r;
  assign out_drive   = drive_r;
  assign out_nack    = nack_r;
  assign out_applied = applied_r;

endmodule

### design/framed_motor_direction_decoder.sv
// ----------------------------------------------------------------------------
// framed_motor_direction_decoder
// Parses '@' count {hi lo}* '*' frames and commits motor H-bridge directions.
//
//   Channel   Dir  Payload                              Handshake
//   in_byte   in   rx_byte[7:0]                         valid/ready
//   out_res   out  drive_pins[15:0], nack, frame_applied valid/ready
//
// One result per byte. A byte is parsed in the cycle it is taken; its
// command is registered in the queue and its result in the output register;
// one byte per cycle is sustained while results are taken.
// Reset is synchronous; all pins low and the parser waits for '@'.
// A stalled output fills the two-entry command queue, after which
// in_byte.ready drops until a result is taken.
// ----------------------------------------------------------------------------
module framed_motor_direction_decoder
  import fmdd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  fmdd_in_if.sink  in_byte,
  fmdd_out_if.source out_res
);

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic queue_full;
  logic queue_empty;
  logic queue_pop;
  logic in_take;

  assign in_byte.ready = !queue_full;
  assign in_take       = in_byte.valid && !queue_full;

  fmdd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_take),
    .rx_byte (in_byte.rx_byte),
    .cmd     (front_cmd)
  );

  fmdd_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_take),
    .push_cmd (front_cmd),
    .full     (queue_full),
    .pop      (queue_pop),
    .empty    (queue_empty),
    .pop_cmd  (queue_cmd)
  );

  fmdd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (!queue_empty),
    .cmd         (queue_cmd),
    .cmd_pop     (queue_pop),
    .out_valid   (out_res.valid),
    .out_ready   (out_res.ready),
    .out_drive   (out_res.drive_pins),
    .out_nack    (out_res.nack),
    .out_applied (out_res.frame_applied)
  );

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Byte-stream test of the framed motor direction decoder. Directed frames
// cover empty counts, extreme magnitudes, ignored ids and bad stop bytes.
// Random framed traffic follows, with noise, cut-short and restarted frames.
// A cycle-free decoder model predicts every result. Bursty sending and
// patterned output stalls vary the timing.
// ----------------------------------------------------------------------------
module tb_top
  import fmdd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic [DRIVE_W-1:0] drive_pins;
    logic               nack;
    logic               frame_applied;
  } drive_result_t;

  logic clk;
  logic rst_n;

  fmdd_in_if  in_if ();
  fmdd_out_if out_if ();

  framed_motor_direction_decoder u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_byte (in_if.sink),
    .out_res (out_if.source)
  );

  // Byte stream waiting to go out, and results still owed by the decoder
  logic [BYTE_W-1:0] pending_bytes[$];
  drive_result_t     expected_results[$];
  int                gen_count;
  bit                restart_pending;
  int                mismatch_count;

  // Decoder state as the testbench sees it
  phase_t             parser_phase;
  logic [7:0]         entries_to_go;
  logic [BYTE_W-1:0]  hi_latch;
  logic [DRIVE_W-1:0] shadow_pins;
  logic [DRIVE_W-1:0] committed_pins;

  // Sender and receiver pacing
  int          burst_left;
  int          gap_left;
  logic [15:0] ready_pattern;
  logic [3:0]  pattern_pos;
  int          pattern_left;
  int          idle_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void decode_rx_byte(logic [BYTE_W-1:0] rx);
    drive_result_t res;
    logic [ID_W-1:0] id;
    logic [9:0]      mag;
    logic [1:0]      pair;
    int              shift;
    res = '0;
    case (parser_phase)
      PH_COUNT: begin
        entries_to_go = rx;
        parser_phase  = (rx == 8'd0) ? PH_STOP : PH_HIGH;
      end
      PH_HIGH: begin
        hi_latch     = rx;
        parser_phase = PH_LOW;
      end
      PH_LOW: begin
        id  = ID_W'((hi_latch & ID_MASK) >> 3);
        mag = {hi_latch[1:0] & MAG_HI_MASK[1:0], rx};
        if (id >= 1 && id <= NUM_MOTORS && id <= 8) begin
          shift = 2 * (id - 1);
          if (mag == 10'd0)
            pair = PAIR_OFF;
          else if ((hi_latch & SIGN_MASK) != 8'd0)
            pair = PAIR_R;
          else
            pair = PAIR_L;
          shadow_pins = (shadow_pins & ~(16'h3 << shift)) | (16'(pair) << shift);
        end
        entries_to_go = entries_to_go - 8'd1;
        parser_phase  = (entries_to_go == 8'd0) ? PH_STOP : PH_HIGH;
      end
      PH_STOP: begin
        if (rx == STOP_BYTE) begin
          committed_pins    = shadow_pins;
          res.frame_applied = 1'b1;
          parser_phase      = PH_WAIT;
        end else begin
          res.nack    = 1'b1;
          shadow_pins = committed_pins;
          // a start byte in the stop slot opens the next frame at once
          parser_phase = (rx == START_BYTE) ? PH_COUNT : PH_WAIT;
        end
      end
      default: begin
        if (rx == START_BYTE) begin
          shadow_pins  = committed_pins;
          parser_phase = PH_COUNT;
        end else begin
          parser_phase = PH_WAIT;
        end
      end
    endcase
    res.drive_pins = committed_pins;
    expected_results.push_back(res);
  endfunction

  function automatic void push_byte(logic [BYTE_W-1:0] b);
    pending_bytes.push_back(b);
    gen_count++;
  endfunction

  function automatic void push_entry(int id, bit sign, logic [9:0] mag);
    push_byte({id[ID_W-1:0], sign, mag[9:8]});
    push_byte(mag[7:0]);
  endfunction

  // One frame of random content; a negative size picks a random count.
  // A few frames are cut short, and the stop slot sometimes holds a bad byte.
  function automatic void gen_frame(int n_entries);
    int              cnt;
    int              cut;
    int              id;
    logic [9:0]      mag;
    logic [BYTE_W-1:0] b;
    int              r;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        b = 8'($urandom);
        if (b == START_BYTE)
          b = 8'h00;
        push_byte(b);
      end
    end
    if (!restart_pending)
      push_byte(START_BYTE);
    restart_pending = 1'b0;
    if (n_entries >= 0) begin
      cnt = n_entries;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 6)
        cnt = 0;
      else if (r < 90)
        cnt = $urandom_range(1, 6);
      else if (r < 98)
        cnt = $urandom_range(7, 20);
      else
        cnt = $urandom_range(21, 40);
    end
    push_byte(8'(cnt));
    cut = ($urandom_range(0, 24) == 0) ? $urandom_range(0, cnt) : -1;
    for (int i = 0; i < cnt; i++) begin
      if (i == cut)
        return;
      id = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 9) : $urandom_range(0, 31);
      r = $urandom_range(0, 99);
      if (r < 20)
        mag = 10'd0;
      else if (r < 30)
        mag = 10'h3FF;
      else if (r < 40)
        mag = {2'($urandom_range(1, 3)), 8'h00};
      else
        mag = 10'($urandom);
      push_entry(id, 1'($urandom), mag);
    end
    if (cut >= 0)
      return;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      push_byte(STOP_BYTE);
    end else if (r < 90) begin
      push_byte(START_BYTE);
      restart_pending = 1'b1;
    end else begin
      b = 8'($urandom);
      if (b == STOP_BYTE)
        b = b ^ 8'h01;
      push_byte(b);
      restart_pending = (b == START_BYTE);
    end
  endfunction

  // Sender: bursts of random length, random gaps between them
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid   <= 1'b0;
      in_if.rx_byte <= '0;
      burst_left    <= 4;
      gap_left      <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (gap_left != 0 || pending_bytes.size() == 0) begin
        in_if.valid <= 1'b0;
        if (gap_left != 0)
          gap_left <= gap_left - 1;
      end else begin
        in_if.valid   <= 1'b1;
        in_if.rx_byte <= pending_bytes.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver: stall on a rotating pattern, changed now and then
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready  <= 1'b0;
      ready_pattern <= 16'hFFFF;
      pattern_pos   <= '0;
      pattern_left  <= 40;
    end else begin
      if (pattern_left == 0) begin
        pattern_left <= $urandom_range(30, 200);
        case ($urandom_range(0, 3))
          0:       ready_pattern <= 16'hFFFF;
          1:       ready_pattern <= 16'($urandom) | 16'h0001;
          2:       ready_pattern <= 16'($urandom & $urandom) | 16'h0001;
          default: ready_pattern <= 16'h0001;
        endcase
      end else begin
        pattern_left <= pattern_left - 1;
      end
      out_if.ready <= ready_pattern[pattern_pos];
      pattern_pos  <= pattern_pos + 4'd1;
    end
  end

  // Predict on each accepted request, then check each accepted result
  always @(posedge clk) begin
    drive_result_t want;
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        decode_rx_byte(in_if.rx_byte);
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result drive_pins=%h nack=%b frame_applied=%b",
                     $realtime, out_if.drive_pins, out_if.nack, out_if.frame_applied);
        end else begin
          want = expected_results.pop_front();
          if (out_if.drive_pins !== want.drive_pins || out_if.nack !== want.nack ||
              out_if.frame_applied !== want.frame_applied) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: drive_pins %h/%h nack %b/%b frame_applied %b/%b (exp/act)",
                       $realtime, want.drive_pins, out_if.drive_pins, want.nack,
                       out_if.nack, want.frame_applied, out_if.frame_applied);
          end
        end
      end
    end
  end

  // Watchdog: too long without any request moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.rx_byte   = '0;
    out_if.ready    = 1'b0;
    idle_cycles     = 0;
    mismatch_count  = 0;
    gen_count       = 0;
    restart_pending = 1'b0;
    parser_phase    = PH_WAIT;
    entries_to_go   = '0;
    hi_latch        = '0;
    shadow_pins     = '0;
    committed_pins  = '0;

    // Noise before any frame, then an empty frame
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(START_BYTE);
    push_byte(8'd0);
    push_byte(STOP_BYTE);
    // Full-scale R, minimum L on the top motor (its high byte looks like a
    // start byte), and id zero which must be dropped
    push_byte(START_BYTE);
    push_byte(8'd3);
    push_entry(1, 1'b1, 10'h3FF);
    push_entry(8, 1'b0, 10'h001);
    push_entry(0, 1'b1, 10'h3FF);
    push_byte(STOP_BYTE);
    // Out-of-range id and a zero magnitude, then a start byte in the stop
    // slot; the restarted frame ends on a plain bad stop byte
    push_byte(START_BYTE);
    push_byte(8'd2);
    push_entry(9, 1'b1, 10'h010);
    push_entry(1, 1'b0, 10'h000);
    push_byte(START_BYTE);
    push_byte(8'd1);
    push_entry(31, 1'b1, 10'h155);
    push_byte(8'h00);

    while (gen_count < 525)
      gen_frame(-1);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Hold the sender until the decoder has answered everything
    do
      @(negedge clk);
    while (pending_bytes.size() != 0 || in_if.valid || expected_results.size() != 0);

    gen_frame(255);
    while (gen_count < 1025)
      gen_frame(-1);

    do
      @(negedge clk);
    while (pending_bytes.size() != 0 || in_if.valid || expected_results.size() != 0);
    repeat (10) @(negedge clk);

    if (mismatch_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
